// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// No dependencies; used by every other file of the block.
`default_nettype none

package bfa_pkg;

    // Fixed field widths
    localparam int PF_W     = 12;
    localparam int STATUS_W = 3;
    localparam int TDATA_W  = 16;

    // Defaults for the top-level parameters
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // Bits examined per cycle by the bit scanner
    localparam int SCAN_CHUNK = 8;

    // Reciprocal shift used to split a frame number into word and bit
    localparam int DIV_SHIFT = 24;

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } bfa_func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_ALLOCATED = 3'd0,
        STAT_MAPPED    = 3'd1,
        STAT_FREED     = 3'd2,
        STAT_NOTHING   = 3'd3,
        STAT_FULL      = 3'd4
    } bfa_status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_BITS,
        ST_FREE_DIV,
        ST_FREE_RD,
        ST_EMIT
    } bfa_state_t;

endpackage

`default_nettype wire

// ===== rtl/bfa_bitscan.sv =====
// Multi-cycle first-zero finder over one bitmap word, SCAN_CHUNK bits a cycle.
// Depends on bfa_pkg.
`default_nettype none

module bfa_bitscan #(
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [WORD_BITS-1:0]         word,
    output logic                              done,
    output logic [$clog2(WORD_BITS)-1:0]      idx
);

    localparam int IDX_W = $clog2(WORD_BITS);
    localparam int CHUNK = bfa_pkg::SCAN_CHUNK;

    logic                 busy_reg;
    logic                 busy_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [IDX_W-1:0]     off_reg;
    logic [IDX_W-1:0]     off_next;
    logic                 hit;
    logic [IDX_W-1:0]     k_sel;

    always_comb
    begin
        hit   = 1'b0;
        k_sel = '0;
        for (int k = CHUNK - 1; k >= 0; k--)
        begin
            if (!word_reg[k])
            begin
                hit   = 1'b1;
                k_sel = IDX_W'(k);
            end
        end
    end

    assign done = busy_reg & hit;
    assign idx  = IDX_W'(off_reg + k_sel);

    always_comb
    begin
        busy_next = busy_reg;
        word_next = word_reg;
        off_next  = off_reg;
        if (start)
        begin
            busy_next = 1'b1;
            word_next = word;
            off_next  = '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // advance one chunk, fill with ones so the padding never matches
                word_next = (word_reg >> CHUNK) | ~({WORD_BITS{1'b1}} >> CHUNK);
                off_next  = IDX_W'(off_reg + IDX_W'(CHUNK));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        off_reg  <= off_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_frame_allocator_top.sv =====
// Top level of the bitmap frame allocator: sequencer, bitmap memory, output register.
// Depends on bfa_pkg and bfa_bitscan.
`default_nettype none

// First-fit physical frame allocator over a bitmap held in a one-read,
// one-write memory of NUM_WORDS = ceil(NUM_FRAMES / WORD_BITS) words.
// After reset the block sweeps the memory to zero, one word a cycle,
// before it raises s_tready. One request is handled at a time. An
// allocate of an already mapped page, a free of frame zero and a free of
// frame NUM_FRAMES or above are answered without touching the memory. A
// free does a reciprocal multiply for the word index, then a
// read-modify-write of the word. An allocate reads one word a cycle from
// word zero until it finds a word with a free bit, then the bit scanner
// finds that bit, 8 bits a cycle. A full bitmap returns status 4.
module bitmap_frame_allocator_top #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [11:0] page_frame, [12] kernel_page, [13] page_writable, [15:14] zero
    input  wire logic [bfa_pkg::TDATA_W-1:0]   s_tdata,
    // [0] func
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [11:0] frame, [12] present, [13] writable, [14] user, [15] zero
    output logic [bfa_pkg::TDATA_W-1:0]        m_tdata,
    // [2:0] status
    output logic [bfa_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int PF_W      = bfa_pkg::PF_W;
    localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int FW        = $clog2(NUM_WORDS * WORD_BITS);
    localparam int RECIP     = ((1 << bfa_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = PF_W + RECIP_W;

    bfa_pkg::bfa_state_t state_reg;
    bfa_pkg::bfa_state_t state_next;

    logic [AW-1:0]        clr_addr_reg;
    logic [AW-1:0]        clr_addr_next;
    logic [AW-1:0]        scan_w_reg;
    logic [AW-1:0]        scan_w_next;
    logic [FW-1:0]        base_reg;
    logic [FW-1:0]        base_next;
    logic [PF_W-1:0]      q_reg;
    logic [PF_W-1:0]      q_next;
    logic [PF_W-1:0]      pf_reg;
    logic [PF_W-1:0]      pf_next;
    logic [IDX_W-1:0]     bit_reg;
    logic [IDX_W-1:0]     bit_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 kern_reg;
    logic                 kern_next;
    logic                 wr_reg;
    logic                 wr_next;

    bfa_pkg::bfa_status_t res_status_reg;
    bfa_pkg::bfa_status_t res_status_next;
    logic [PF_W-1:0]      res_frame_reg;
    logic [PF_W-1:0]      res_frame_next;
    logic                 res_present_reg;
    logic                 res_present_next;
    logic                 res_writable_reg;
    logic                 res_writable_next;
    logic                 res_user_reg;
    logic                 res_user_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_load;
    bfa_pkg::bfa_status_t out_status_reg;
    logic [PF_W-1:0]      out_frame_reg;
    logic                 out_present_reg;
    logic                 out_writable_reg;
    logic                 out_user_reg;

    // Bitmap memory
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    // Request unpacking
    bfa_pkg::bfa_func_t   in_func;
    logic [PF_W-1:0]      in_pf;
    logic                 in_kern;
    logic                 in_wr;
    logic [PROD_W-1:0]    div_prod;

    logic                 scan_start;
    logic                 scan_done;
    logic [IDX_W-1:0]     scan_idx;
    logic [FW-1:0]        f_sum;

    assign in_func  = bfa_pkg::bfa_func_t'(s_tuser);
    assign in_pf    = s_tdata[PF_W-1:0];
    assign in_kern  = s_tdata[PF_W];
    assign in_wr    = s_tdata[PF_W+1];
    assign div_prod = PROD_W'(in_pf) * PROD_W'(RECIP);
    assign f_sum    = FW'(base_reg + FW'(scan_idx));

    assign s_tready = (state_reg == bfa_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_user_reg, out_writable_reg, out_present_reg, out_frame_reg};
    assign m_tuser  = out_status_reg;

    bfa_bitscan #(
        .WORD_BITS (WORD_BITS)
    ) u_bfa_bitscan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .word  (rd_data_reg),
        .done  (scan_done),
        .idx   (scan_idx)
    );

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        scan_w_next       = scan_w_reg;
        base_next         = base_reg;
        q_next            = q_reg;
        pf_next           = pf_reg;
        bit_next          = bit_reg;
        word_next         = word_reg;
        kern_next         = kern_reg;
        wr_next           = wr_reg;
        res_status_next   = res_status_reg;
        res_frame_next    = res_frame_reg;
        res_present_next  = res_present_reg;
        res_writable_next = res_writable_reg;
        res_user_next     = res_user_reg;
        mem_we            = 1'b0;
        mem_waddr         = clr_addr_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        scan_start        = 1'b0;
        out_load          = 1'b0;

        unique case (state_reg)
            bfa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(NUM_WORDS - 1))
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = AW'(clr_addr_reg + 1'b1);
                end
            end

            bfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pf_next           = in_pf;
                    kern_next         = in_kern;
                    wr_next           = in_wr;
                    res_frame_next    = '0;
                    res_present_next  = 1'b0;
                    res_writable_next = 1'b0;
                    res_user_next     = 1'b0;
                    if (in_func == bfa_pkg::FUNC_ALLOC)
                    begin
                        if (in_pf != '0)
                        begin
                            res_status_next = bfa_pkg::STAT_MAPPED;
                            res_frame_next  = in_pf;
                            state_next      = bfa_pkg::ST_EMIT;
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = '0;
                            scan_w_next = '0;
                            base_next   = '0;
                            state_next  = bfa_pkg::ST_SCAN;
                        end
                    end
                    else
                    begin
                        priority if (in_pf == '0)
                        begin
                            res_status_next = bfa_pkg::STAT_NOTHING;
                            state_next      = bfa_pkg::ST_EMIT;
                        end
                        else if (32'(in_pf) < NUM_FRAMES)
                        begin
                            q_next     = PF_W'(div_prod >> bfa_pkg::DIV_SHIFT);
                            state_next = bfa_pkg::ST_FREE_DIV;
                        end
                        else
                        begin
                            res_status_next = bfa_pkg::STAT_FREED;
                            state_next      = bfa_pkg::ST_EMIT;
                        end
                    end
                end
            end

            bfa_pkg::ST_SCAN:
            begin
                // rd_data_reg holds word scan_w_reg; skip it when full
                if (rd_data_reg != {WORD_BITS{1'b1}})
                begin
                    scan_start = 1'b1;
                    word_next  = rd_data_reg;
                    state_next = bfa_pkg::ST_BITS;
                end
                else if (scan_w_reg == AW'(NUM_WORDS - 1))
                begin
                    res_status_next = bfa_pkg::STAT_FULL;
                    state_next      = bfa_pkg::ST_EMIT;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = AW'(scan_w_reg + 1'b1);
                    scan_w_next = AW'(scan_w_reg + 1'b1);
                    base_next   = FW'(base_reg + FW'(WORD_BITS));
                end
            end

            bfa_pkg::ST_BITS:
            begin
                if (scan_done)
                begin
                    // a free bit past the last frame means the bitmap is full
                    if (32'(f_sum) >= NUM_FRAMES)
                    begin
                        res_status_next = bfa_pkg::STAT_FULL;
                    end
                    else
                    begin
                        mem_we            = 1'b1;
                        mem_waddr         = scan_w_reg;
                        mem_wdata         = word_reg | (WORD_BITS'(1) << scan_idx);
                        res_status_next   = bfa_pkg::STAT_ALLOCATED;
                        res_frame_next    = PF_W'(f_sum);
                        res_present_next  = 1'b1;
                        res_writable_next = wr_reg;
                        res_user_next     = ~kern_reg;
                    end
                    state_next = bfa_pkg::ST_EMIT;
                end
            end

            bfa_pkg::ST_FREE_DIV:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(q_reg);
                bit_next   = IDX_W'(PF_W'(pf_reg - PF_W'(q_reg * WORD_BITS)));
                state_next = bfa_pkg::ST_FREE_RD;
            end

            bfa_pkg::ST_FREE_RD:
            begin
                mem_we          = 1'b1;
                mem_waddr       = AW'(q_reg);
                mem_wdata       = rd_data_reg & ~(WORD_BITS'(1) << bit_reg);
                res_status_next = bfa_pkg::STAT_FREED;
                state_next      = bfa_pkg::ST_EMIT;
            end

            bfa_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = bfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_w_reg       <= scan_w_next;
        base_reg         <= base_next;
        q_reg            <= q_next;
        pf_reg           <= pf_next;
        bit_reg          <= bit_next;
        word_reg         <= word_next;
        kern_reg         <= kern_next;
        wr_reg           <= wr_next;
        res_status_reg   <= res_status_next;
        res_frame_reg    <= res_frame_next;
        res_present_reg  <= res_present_next;
        res_writable_reg <= res_writable_next;
        res_user_reg     <= res_user_next;
        if (out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_frame_reg    <= res_frame_reg;
            out_present_reg  <= res_present_reg;
            out_writable_reg <= res_writable_reg;
            out_user_reg     <= res_user_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfa_checker.sv =====
// Port-level checks for the bitmap frame allocator, bound to its top level.
// Depends on bfa_pkg and bitmap_frame_allocator_top.
`default_nettype none

module bfa_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [bfa_pkg::TDATA_W-1:0] m_tdata,
    input wire logic [bfa_pkg::STATUS_W-1:0] m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One request at a time: busy right after an accepted request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in progress");

    // Present bit is set exactly for a fresh allocation
    a_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12] == (m_tuser == bfa_pkg::STAT_ALLOCATED)))
        else $error("present bit does not match status");

    // Only allocated and mapped results carry a frame number
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bfa_pkg::STAT_ALLOCATED && m_tuser != bfa_pkg::STAT_MAPPED
        |-> m_tdata[11:0] == 12'd0)
        else $error("frame nonzero on free or full result");

    // A new result appears only while the input side is closed
    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced while idle");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);

`default_nettype wire
